// File: sv/lfd_pkg.sv
// shared types and constants for the lidar frame decoder
`timescale 1ns / 1ps
package lfd_pkg;
    localparam int SENSOR_COUNT = 3;
    localparam int SENSOR_W     = 2;
    localparam int FRAME_BYTES  = 9;
    localparam int POS_W        = 4;
    localparam int SLOT_W       = 3;

    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_INFO = 2'd2;

    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_DATA = 2'd1;
    localparam logic [1:0] EV_RESP = 2'd2;
    localparam logic [1:0] EV_REJ  = 2'd3;

    localparam logic [7:0]  HDR_DATA   = 8'h59;
    localparam logic [7:0]  HDR_RESP   = 8'h5A;
    localparam logic [15:0] STR_SAT    = 16'hFFFF;
    localparam logic [31:0] BAUD_DEF   = 32'd115200;
    localparam logic [15:0] RATE_DEF   = 16'd100;
    localparam logic [15:0] THRESH_DEF = 16'd100;
    localparam logic [16:0] DIST_WEAK  = 17'h1FFFF;
    localparam logic [16:0] DIST_NONE  = 17'h1FFFE;

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] sensor;
        logic [7:0] data_byte;
    } req_t;

    typedef struct packed {
        logic        error;
        logic [1:0]  frame_event;
        logic [16:0] distance;
        logic [15:0] strength;
        logic [15:0] temperature;
        logic [23:0] version;
        logic [15:0] frame_rate;
        logic [31:0] baud_rate;
        logic [1:0]  output_format;
        logic [7:0]  response_count;
    } rsp_t;

    // per-sensor record held in the state memory
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [7:0]       sum;
        logic [15:0]      range_cm;
        logic             stale;
        logic [15:0]      str;
        logic [15:0]      temp;
        logic [23:0]      ver;
        logic [15:0]      rate;
        logic [31:0]      baud;
        logic [1:0]       fmt;
        logic [7:0]       cnt;
    } sens_t;

    // bytes 0..7 of the current frame, byte 8 arrives live
    typedef logic [FRAME_BYTES-2:0][7:0] frame_t;
endpackage

// File: sv/lfd_if.sv
// valid/ready channel interface
`timescale 1ns / 1ps
interface lfd_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: sv/lfd_classify.sv
// frame classification and per-sensor record update
`timescale 1ns / 1ps
module lfd_classify (
    input  lfd_pkg::sens_t  cur,
    input  lfd_pkg::frame_t fb,
    input  logic [7:0]      last_byte,
    output lfd_pkg::sens_t  upd,
    output logic [1:0]      ev
);
    import lfd_pkg::*;

    logic [7:0] s5, s6, s7, s8;

    function automatic logic pat(input frame_t b, input logic [7:0] p1, input logic [7:0] p2,
                                 input logic [7:0] p3, input logic [7:0] p4);
        return b[1] == p1 && b[2] == p2 && b[3] == p3 && b[4] == p4;
    endfunction

    always_comb
    begin
        s5 = fb[0] + fb[1] + fb[2] + fb[3] + fb[4];
        s6 = s5 + fb[5];
        s7 = s6 + fb[6];
        s8 = cur.sum;
        upd = cur;
        ev = EV_REJ;
        if (fb[0] == HDR_DATA)
        begin
            if (fb[1] == HDR_DATA && s8 == last_byte)
            begin
                upd.range_cm = {fb[3], fb[2]};
                upd.str = {fb[5], fb[4]};
                upd.temp = {fb[7], fb[6]};
                upd.stale = 1'b0;
                ev = EV_DATA;
            end
        end
        else if (fb[0] == HDR_RESP)
        begin
            ev = EV_RESP;
            if (fb[1] == 8'h07 && fb[2] == 8'h01)
            begin
                if (s6 != fb[6]) ev = EV_REJ;
                else upd.ver = {fb[5], fb[4], fb[3]};
            end
            else if (fb[1] == 8'h06 && fb[2] == 8'h03)
            begin
                if (s5 != fb[5]) ev = EV_REJ;
                else upd.rate = {fb[4], fb[3]};
            end
            else if (fb[1] == 8'h08 && fb[2] == 8'h06)
            begin
                if (s7 != fb[7]) ev = EV_REJ;
                else upd.baud = {fb[6], fb[5], fb[4], fb[3]};
            end
            else if (pat(fb, 8'h05, 8'h05, 8'h01, 8'h65)) upd.fmt = 2'd1;
            else if (pat(fb, 8'h05, 8'h05, 8'h02, 8'h66)) upd.fmt = 2'd2;
            else if (pat(fb, 8'h05, 8'h05, 8'h03, 8'h67)) upd.fmt = 2'd3;
            else if (pat(fb, 8'h05, 8'h10, 8'h00, 8'h6E))
            begin
                upd.baud = BAUD_DEF;
                upd.rate = RATE_DEF;
                upd.fmt = 2'd1;
            end
            else if (pat(fb, 8'h05, 8'h02, 8'h00, 8'h60) || pat(fb, 8'h05, 8'h02, 8'h01, 8'h61) ||
                     pat(fb, 8'h05, 8'h07, 8'h00, 8'h66) || pat(fb, 8'h05, 8'h07, 8'h01, 8'h67) ||
                     pat(fb, 8'h05, 8'h10, 8'h01, 8'h6F) || pat(fb, 8'h05, 8'h22, 8'h00, 8'h6F) ||
                     pat(fb, 8'h05, 8'h22, 8'h01, 8'h70))
            begin
                upd.ver = cur.ver;
            end
            else ev = EV_REJ;
            if (ev == EV_RESP) upd.cnt = cur.cnt + 8'd1;
        end
    end
endmodule

// File: sv/lidar_frame_decoder_top.sv
// a request is registered into stage 1 and its result into the output register
// one request per cycle unless the output stalls; each record is read, modified, written back
// a request that follows one for the same sensor takes the record being written through a bypass
// reset clears control state and sets every sensor record to its default values
// frame byte memory needs no clearing pass
`timescale 1ns / 1ps
module lidar_frame_decoder_top (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [15:0] cfg_wdata,
    lfd_if.sink   in_ch,
    lfd_if.source out_ch
);
    import lfd_pkg::*;

    localparam int SLOTS = SENSOR_COUNT * (FRAME_BYTES - 1);

    sens_t sens_mem [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] init_reg;
    logic [7:0] fb_mem [SLOTS];

    logic [15:0] thresh_reg;
    logic s1_valid_reg, s1_ok_reg;
    req_t s1_req_reg;
    sens_t rd_reg, cur, upd, nxt;
    frame_t fb_reg;
    logic [1:0] ev;
    rsp_t res, out_reg;
    logic out_valid_reg;
    logic stall, accept, in_ok;
    logic s1_adv, sens_we, fb_we, same_sensor;
    logic [POS_W-1:0] pos;

    sens_t dflt;
    always_comb
    begin
        dflt = '0;
        dflt.stale = 1'b1;
        dflt.rate = RATE_DEF;
        dflt.baud = BAUD_DEF;
    end

    assign stall = out_valid_reg && !out_ch.ready && s1_valid_reg;
    assign in_ch.ready = !stall;
    assign accept = in_ch.valid && in_ch.ready;
    assign in_ok = {30'd0, in_ch.payload.sensor} < SENSOR_COUNT;
    assign s1_adv = s1_valid_reg && !stall;
    assign sens_we = s1_adv && s1_ok_reg;
    assign fb_we = sens_we && s1_req_reg.opcode == OP_BYTE && pos < POS_W'(FRAME_BYTES - 1);
    assign same_sensor = s1_req_reg.sensor == in_ch.payload.sensor;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= THRESH_DEF;
        else if (cfg_we)
            thresh_reg <= cfg_wdata;
    end

    // stage 1 memory reads with bypass of the write in progress, and the memory writes
    always_ff @(posedge clk)
    begin
        if (accept && in_ok)
        begin
            if (sens_we && same_sensor)
                rd_reg <= nxt;
            else
                rd_reg <= sens_mem[in_ch.payload.sensor];
            for (int i = 0; i < FRAME_BYTES - 1; i++)
            begin
                if (fb_we && same_sensor && pos[SLOT_W-1:0] == SLOT_W'(i))
                    fb_reg[i] <= s1_req_reg.data_byte;
                else
                    fb_reg[i] <= fb_mem[{in_ch.payload.sensor, SLOT_W'(i)}];
            end
        end
        if (sens_we)
            sens_mem[s1_req_reg.sensor] <= nxt;
        if (fb_we)
            fb_mem[{s1_req_reg.sensor, pos[SLOT_W-1:0]}] <= s1_req_reg.data_byte;
        if (accept)
            s1_req_reg <= in_ch.payload;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_ok_reg <= 1'b0;
            init_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!stall)
            begin
                s1_valid_reg <= accept;
                s1_ok_reg <= in_ok;
            end
            if (sens_we)
                init_reg[s1_req_reg.sensor] <= 1'b1;
            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        if (!init_reg[s1_req_reg.sensor])
            cur = dflt;
        else
            cur = rd_reg;
        pos = (cur.pos >= POS_W'(FRAME_BYTES)) ? '0 : cur.pos;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            out_reg <= res;
    end

    lfd_classify u_classify (
        .cur(cur), .fb(fb_reg), .last_byte(s1_req_reg.data_byte), .upd(upd), .ev(ev)
    );

    always_comb
    begin
        nxt = cur;
        res = '0;
        if (!s1_ok_reg)
            res.error = 1'b1;
        else
        begin
            unique case (s1_req_reg.opcode)
                OP_BYTE:
                begin
                    if (pos == POS_W'(FRAME_BYTES - 1))
                    begin
                        nxt = upd;
                        nxt.pos = '0;
                        res.frame_event = ev;
                    end
                    else
                    begin
                        nxt.pos = pos + POS_W'(1);
                        nxt.sum = (pos == '0) ? s1_req_reg.data_byte
                                              : cur.sum + s1_req_reg.data_byte;
                    end
                end
                OP_READ:
                begin
                    if (cur.stale)
                        res.distance = DIST_NONE;
                    else if (cur.str >= thresh_reg && cur.str != STR_SAT)
                    begin
                        res.distance = {1'b0, cur.range_cm};
                        res.strength = cur.str;
                        res.temperature = cur.temp;
                    end
                    else
                        res.distance = DIST_WEAK;
                    nxt.stale = 1'b1;
                end
                OP_INFO:
                begin
                    res.version = cur.ver;
                    res.frame_rate = cur.rate;
                    res.baud_rate = cur.baud;
                    res.output_format = cur.fmt;
                    res.response_count = cur.cnt;
                    nxt.cnt = '0;
                end
                default: nxt = cur;
            endcase
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.payload = out_reg;

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !stall && !s1_ok_reg) |=> out_reg.error)
        else $error("unknown sensor without error flag");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> (out_valid_reg && $stable(out_reg)))
        else $error("result changed while stalled");
    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_ok_reg) |-> cur.pos < POS_W'(FRAME_BYTES))
        else $error("byte position out of range");
endmodule

// File: test/testbench.sv
// testbench for the lidar frame decoder: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module testbench;
    import lfd_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [15:0] cfg_wdata;

    lfd_if #(.payload_t(req_t)) req_ch ();
    lfd_if #(.payload_t(rsp_t)) rsp_ch ();

    lidar_frame_decoder_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch(req_ch),
        .out_ch(rsp_ch)
    );

    // predictor state
    logic [15:0] thresh;
    logic [7:0]  fbuf [SENSOR_COUNT][FRAME_BYTES];
    int          fpos [SENSOR_COUNT];
    logic [15:0] p_dist [SENSOR_COUNT];
    logic        p_stale [SENSOR_COUNT];
    logic [15:0] p_str [SENSOR_COUNT];
    logic [15:0] p_temp [SENSOR_COUNT];
    logic [23:0] p_ver [SENSOR_COUNT];
    logic [15:0] p_rate [SENSOR_COUNT];
    logic [31:0] p_baud [SENSOR_COUNT];
    logic [1:0]  p_fmt [SENSOR_COUNT];
    logic [7:0]  p_cnt [SENSOR_COUNT];

    rsp_t expected_rsps [$];
    int   mismatches = 0;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_len;
    int   hold_count;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = 1'b1;
            #6 clk = 1'b0;
        end
    end

    initial
    begin
        #200ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [7:0] sum_bytes(int s, int n);
        logic [7:0] acc;
        acc = 8'd0;
        for (int i = 0; i < n; i++)
            acc = acc + fbuf[s][i];
        return acc;
    endfunction

    function automatic bit resp_pat(int s, logic [7:0] a, logic [7:0] b,
                                    logic [7:0] c, logic [7:0] d);
        return fbuf[s][1] == a && fbuf[s][2] == b && fbuf[s][3] == c && fbuf[s][4] == d;
    endfunction

    function automatic logic [1:0] classify_frame(int s);
        if (fbuf[s][0] == HDR_DATA)
        begin
            if (fbuf[s][1] == HDR_DATA && sum_bytes(s, 8) == fbuf[s][8])
            begin
                p_dist[s] = {fbuf[s][3], fbuf[s][2]};
                p_str[s] = {fbuf[s][5], fbuf[s][4]};
                p_temp[s] = {fbuf[s][7], fbuf[s][6]};
                p_stale[s] = 1'b0;
                return EV_DATA;
            end
            return EV_REJ;
        end
        if (fbuf[s][0] != HDR_RESP)
            return EV_REJ;
        if (fbuf[s][1] == 8'h07 && fbuf[s][2] == 8'h01)
        begin
            if (sum_bytes(s, 6) != fbuf[s][6])
                return EV_REJ;
            p_ver[s] = {fbuf[s][5], fbuf[s][4], fbuf[s][3]};
        end
        else if (fbuf[s][1] == 8'h06 && fbuf[s][2] == 8'h03)
        begin
            if (sum_bytes(s, 5) != fbuf[s][5])
                return EV_REJ;
            p_rate[s] = {fbuf[s][4], fbuf[s][3]};
        end
        else if (fbuf[s][1] == 8'h08 && fbuf[s][2] == 8'h06)
        begin
            if (sum_bytes(s, 7) != fbuf[s][7])
                return EV_REJ;
            p_baud[s] = {fbuf[s][6], fbuf[s][5], fbuf[s][4], fbuf[s][3]};
        end
        else if (resp_pat(s, 8'h05, 8'h05, 8'h01, 8'h65))
            p_fmt[s] = 2'd1;
        else if (resp_pat(s, 8'h05, 8'h05, 8'h02, 8'h66))
            p_fmt[s] = 2'd2;
        else if (resp_pat(s, 8'h05, 8'h05, 8'h03, 8'h67))
            p_fmt[s] = 2'd3;
        else if (resp_pat(s, 8'h05, 8'h10, 8'h00, 8'h6E))
        begin
            p_baud[s] = BAUD_DEF;
            p_rate[s] = RATE_DEF;
            p_fmt[s] = 2'd1;
        end
        else if (!(resp_pat(s, 8'h05, 8'h02, 8'h00, 8'h60)
                || resp_pat(s, 8'h05, 8'h02, 8'h01, 8'h61)
                || resp_pat(s, 8'h05, 8'h07, 8'h00, 8'h66)
                || resp_pat(s, 8'h05, 8'h07, 8'h01, 8'h67)
                || resp_pat(s, 8'h05, 8'h10, 8'h01, 8'h6F)
                || resp_pat(s, 8'h05, 8'h22, 8'h00, 8'h6F)
                || resp_pat(s, 8'h05, 8'h22, 8'h01, 8'h70)))
            return EV_REJ;
        p_cnt[s] = p_cnt[s] + 8'd1;
        return EV_RESP;
    endfunction

    function automatic rsp_t decode_request(req_t r);
        rsp_t o;
        int s;
        o = '0;
        s = int'(r.sensor);
        if (s >= SENSOR_COUNT)
        begin
            o.error = 1'b1;
            return o;
        end
        if (r.opcode == OP_BYTE)
        begin
            fbuf[s][fpos[s]] = r.data_byte;
            fpos[s]++;
            if (fpos[s] >= FRAME_BYTES)
            begin
                fpos[s] = 0;
                o.frame_event = classify_frame(s);
            end
        end
        else if (r.opcode == OP_READ)
        begin
            if (p_stale[s])
                o.distance = DIST_NONE;
            else if (p_str[s] >= thresh && p_str[s] != STR_SAT)
            begin
                o.distance = {1'b0, p_dist[s]};
                o.strength = p_str[s];
                o.temperature = p_temp[s];
            end
            else
                o.distance = DIST_WEAK;
            p_stale[s] = 1'b1;
        end
        else if (r.opcode == OP_INFO)
        begin
            o.version = p_ver[s];
            o.frame_rate = p_rate[s];
            o.baud_rate = p_baud[s];
            o.output_format = p_fmt[s];
            o.response_count = p_cnt[s];
            p_cnt[s] = 8'd0;
        end
        return o;
    endfunction

    task automatic send_request(logic [1:0] op, logic [1:0] s, logic [7:0] b);
        req_t r;
        r.opcode = op;
        r.sensor = s;
        r.data_byte = b;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected_rsps.push_back(decode_request(r));
    endtask

    task automatic send_frame(logic [1:0] s, logic [7:0] b [9]);
        for (int i = 0; i < 9; i++)
            send_request(OP_BYTE, s, b[i]);
    endtask

    // builds a well-formed frame of a random kind, sometimes corrupted
    task automatic send_random_frame(logic [1:0] s);
        logic [7:0] b [9];
        logic [7:0] acc;
        int kind;
        int n;
        foreach (b[i])
            b[i] = $urandom_range(255);
        kind = $urandom_range(5);
        n = 8;
        case (kind)
            0, 1:
            begin
                b[0] = HDR_DATA;
                b[1] = HDR_DATA;
                if ($urandom_range(3) == 0)
                    b[5] = 8'h00;
                if ($urandom_range(9) == 0)
                begin
                    b[4] = 8'hFF;
                    b[5] = 8'hFF;
                end
            end
            2:
            begin
                b[0] = HDR_RESP;
                b[1] = 8'h07;
                b[2] = 8'h01;
                n = 6;
            end
            3:
            begin
                b[0] = HDR_RESP;
                b[1] = 8'h06;
                b[2] = 8'h03;
                n = 5;
            end
            4:
            begin
                b[0] = HDR_RESP;
                b[1] = 8'h08;
                b[2] = 8'h06;
                n = 7;
            end
            default:
            begin
                b[0] = HDR_RESP;
                b[1] = 8'h05;
                case ($urandom_range(10))
                    0: {b[2], b[3], b[4]} = {8'h05, 8'h01, 8'h65};
                    1: {b[2], b[3], b[4]} = {8'h05, 8'h02, 8'h66};
                    2: {b[2], b[3], b[4]} = {8'h05, 8'h03, 8'h67};
                    3: {b[2], b[3], b[4]} = {8'h10, 8'h00, 8'h6E};
                    4: {b[2], b[3], b[4]} = {8'h02, 8'h00, 8'h60};
                    5: {b[2], b[3], b[4]} = {8'h02, 8'h01, 8'h61};
                    6: {b[2], b[3], b[4]} = {8'h07, 8'h00, 8'h66};
                    7: {b[2], b[3], b[4]} = {8'h07, 8'h01, 8'h67};
                    8: {b[2], b[3], b[4]} = {8'h10, 8'h01, 8'h6F};
                    9: {b[2], b[3], b[4]} = {8'h22, 8'h00, 8'h6F};
                    default: {b[2], b[3], b[4]} = {8'h22, 8'h01, 8'h70};
                endcase
                n = 0;
            end
        endcase
        if (n > 0)
        begin
            acc = 8'd0;
            for (int i = 0; i < n; i++)
                acc = acc + b[i];
            b[n] = acc;
        end
        if ($urandom_range(7) == 0)
            b[$urandom_range(8)] ^= 8'h01 << $urandom_range(7);
        send_frame(s, b);
    endtask

    task automatic drain_results();
        while (expected_rsps.size() > 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_threshold(logic [15:0] v);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        thresh = v;
    endtask

    task automatic test_directed();
        logic [7:0] f [9];
        send_request(OP_READ, 2'd0, 8'h00);
        send_request(OP_INFO, 2'd1, 8'hFF);
        send_request(OP_BYTE, 2'd3, 8'hAA);
        send_request(OP_READ, 2'd3, 8'h00);
        send_request(2'd3, 2'd2, 8'h55);
        f = '{8'h59, 8'h59, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'h00, 8'h80, 8'h00};
        f[8] = f[0] + f[1] + f[2] + f[3] + f[4] + f[5] + f[6] + f[7];
        send_frame(2'd0, f);
        send_request(OP_READ, 2'd0, 8'h00);
        send_request(OP_READ, 2'd0, 8'h00);
        f = '{8'h5A, 8'h05, 8'h10, 8'h00, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00};
        send_frame(2'd2, f);
        send_request(OP_INFO, 2'd2, 8'h00);
        req_ch.valid <= 1'b0;
    endtask

    task automatic test_random(int count);
        int sent;
        logic [1:0] s;
        sent = 0;
        while (sent < count)
        begin
            s = $urandom_range(99) < 4 ? 2'd3 : 2'($urandom_range(2));
            case ($urandom_range(9))
                0, 1, 2, 3, 4:
                begin
                    send_random_frame(s);
                    sent += 9;
                end
                5:
                begin
                    send_request(OP_BYTE, s, 8'($urandom_range(255)));
                    sent++;
                end
                6, 7:
                begin
                    send_request(OP_READ, s, 8'($urandom_range(255)));
                    sent++;
                end
                8:
                begin
                    send_request(OP_INFO, s, 8'($urandom_range(255)));
                    sent++;
                end
                default:
                begin
                    send_request(2'($urandom_range(3)), s, 8'($urandom_range(255)));
                    sent++;
                end
            endcase
        end
        req_ch.valid <= 1'b0;
    endtask

    task automatic test_backpressure();
        hold_len = 200;
        send_idle_pct = 0;
        test_random(60);
        @(posedge clk);
        drain_results();
    endtask

    // receiver: one long hold when requested, random stalls otherwise
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_count <= 0;
        end
        else if (hold_count < hold_len)
        begin
            rsp_ch.ready <= 1'b0;
            hold_count <= hold_count + 1;
        end
        else
            rsp_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", rsp_ch.payload);
            end
            else
            begin
                exp_rsp = expected_rsps.pop_front();
                if (rsp_ch.payload !== exp_rsp)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_rsp, rsp_ch.payload);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        hold_len = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        thresh = THRESH_DEF;
        for (int s = 0; s < SENSOR_COUNT; s++)
        begin
            fpos[s] = 0;
            p_dist[s] = '0;
            p_stale[s] = 1'b1;
            p_str[s] = '0;
            p_temp[s] = '0;
            p_ver[s] = '0;
            p_rate[s] = RATE_DEF;
            p_baud[s] = BAUD_DEF;
            p_fmt[s] = '0;
            p_cnt[s] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_threshold(16'd0);
        test_random(300);
        send_idle_pct = 58;
        write_threshold(16'hFFFF);
        test_random(250);
        send_idle_pct = 0;
        recv_stall_pct = 58;
        write_threshold(16'($urandom_range(65535)));
        test_random(250);
        send_idle_pct = 24;
        recv_stall_pct = 24;
        write_threshold(16'd200);
        test_random(250);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        drain_results();

        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// File: sim.f
sv/lfd_pkg.sv
sv/lfd_if.sv
sv/lfd_classify.sv
sv/lidar_frame_decoder_top.sv
test/testbench.sv
